@@ design/mexp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // fixed field widths
    localparam int CIPHER_W          = 63;
    localparam int DIGIT_W           = 4;
    localparam int BYTE_W            = 8;
    localparam int DEF_MODULUS_BITS  = 63;

    // arithmetic constants
    localparam int DIGIT_BASE        = 10;
    localparam int MOD_RESET         = 2;

    // action codes
    localparam logic ACT_DIGIT = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG,
        S_BASE,
        S_MUL,
        S_SQR,
        S_OUT
    } t_state;

    // status of the modular multiply engine
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

endpackage

`default_nettype wire

@@ design/mexp_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod #(
    parameter int MODULUS_BITS = mexp_pkg::DEF_MODULUS_BITS,
    parameter int OPER_BITS    = MODULUS_BITS + 4,
    localparam int CntW        = $clog2(OPER_BITS + 1)
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire  [CntW-1:0]          i_nbits,
    input  wire  [MODULUS_BITS-1:0]  i_a,
    input  wire  [OPER_BITS-1:0]     i_b,
    input  wire  [MODULUS_BITS-1:0]  i_m,
    output mexp_pkg::t_eng_stat      o_stat,
    output logic [MODULUS_BITS-1:0]  o_result
);
    import mexp_pkg::*;

    localparam int SumW = MODULUS_BITS + 2;

    logic                    r_busy;
    logic                    r_done;
    logic [CntW-1:0]         r_cnt;
    logic [MODULUS_BITS-1:0] r_acc;
    logic [MODULUS_BITS-1:0] r_a;
    logic [MODULUS_BITS-1:0] r_m;
    logic [OPER_BITS-1:0]    r_b;

    logic [SumW-1:0]         sum;
    logic [SumW-1:0]         m_one;
    logic [SumW-1:0]         m_two;
    logic [SumW-1:0]         sum_red;

    // one step: acc = (2*acc + bit*a) mod m, with acc, a < m so sum < 3m
    always_comb begin
        m_one = SumW'(r_m);
        m_two = SumW'(r_m) << 1;
        sum   = (SumW'(r_acc) << 1) + (r_b[OPER_BITS-1] ? SumW'(r_a) : '0);
        priority if (sum >= m_two) begin
            sum_red = sum - m_two;
        end else if (sum >= m_one) begin
            sum_red = sum - m_one;
        end else begin
            sum_red = sum;
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_m   <= i_m;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= sum_red[MODULUS_BITS-1:0];
            r_b   <= r_b << 1;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_acc;

endmodule

`default_nettype wire

@@ design/modexp_byte_encryptor.sv @@
`timescale 1ns / 1ps
`default_nettype none
// exponent digit: one multiply-engine pass over the folded value
// message byte: one pass to reduce the byte modulo n, then the multiplies and squarings;
//   one shared modular step per cycle
// one item at a time; the next item is taken while a finished result waits at the output
// synchronous active-low reset: modulus 2, exponent 0, output empty, sequencer idle

module modexp_byte_encryptor #(
    parameter int MODULUS_BITS = mexp_pkg::DEF_MODULUS_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [mexp_pkg::CIPHER_W-1:0]    i_cfg_wdata,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_action,
    input  wire  [mexp_pkg::DIGIT_W-1:0]     i_exponent_digit,
    input  wire  [mexp_pkg::BYTE_W-1:0]      i_message_byte,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [mexp_pkg::CIPHER_W-1:0]    o_cipher_value
);
    import mexp_pkg::*;

    localparam int MB      = MODULUS_BITS;
    localparam int DigBits = MB + DIGIT_W;
    localparam int OperW   = (DigBits > BYTE_W) ? DigBits : BYTE_W;
    localparam int CntW    = $clog2(OperW + 1);

    t_state          r_state, n_state;
    logic [MB-1:0]   r_mod;
    logic [MB-1:0]   r_exp, n_exp;
    logic [MB-1:0]   r_res, n_res;
    logic [MB-1:0]   r_x, n_x;
    logic [MB-1:0]   r_e, n_e;
    logic            r_ovalid;
    logic [MB-1:0]   r_cipher;

    logic            in_fire;
    logic            load_out;
    logic            mod_small;
    logic [MB-1:0]   e_half;
    logic [OperW-1:0] dig_oper;

    logic            eng_start;
    logic [CntW-1:0] eng_nbits;
    logic [MB-1:0]   eng_a;
    logic [OperW-1:0] eng_b;
    logic [MB-1:0]   eng_m;
    t_eng_stat       eng_stat;
    logic [MB-1:0]   eng_res;

    mexp_mulmod #(
        .MODULUS_BITS (MB),
        .OPER_BITS    (OperW)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (eng_start),
        .i_nbits  (eng_nbits),
        .i_a      (eng_a),
        .i_b      (eng_b),
        .i_m      (eng_m),
        .o_stat   (eng_stat),
        .o_result (eng_res)
    );

    assign in_fire   = i_in_valid && o_in_ready;
    assign mod_small = (r_mod < MB'(MOD_RESET));
    assign e_half    = r_e >> 1;

    // exponent * 10 + digit, exact, left-aligned for the engine
    assign dig_oper = (OperW'(r_exp) * OperW'(DIGIT_BASE) + OperW'(i_exponent_digit))
                      << (OperW - DigBits);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_exp     = r_exp;
        n_res     = r_res;
        n_x       = r_x;
        n_e       = r_e;
        eng_start = 1'b0;
        eng_nbits = CntW'(MB);
        eng_a     = MB'(1);
        eng_b     = '0;
        eng_m     = r_mod;
        load_out  = 1'b0;
        o_in_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_action == ACT_DIGIT) begin
                        if (mod_small) begin
                            n_exp = '0;
                        end else begin
                            // reduce the folded value modulo n - 1
                            eng_start = 1'b1;
                            eng_nbits = CntW'(DigBits);
                            eng_b     = dig_oper;
                            eng_m     = r_mod - MB'(1);
                            n_state   = S_DIG;
                        end
                    end else begin
                        n_e = r_exp;
                        if (mod_small) begin
                            n_res   = '0;
                            n_state = S_OUT;
                        end else begin
                            // reduce the byte modulo n
                            n_res     = MB'(1);
                            eng_start = 1'b1;
                            eng_nbits = CntW'(BYTE_W);
                            eng_b     = OperW'(i_message_byte) << (OperW - BYTE_W);
                            n_state   = S_BASE;
                        end
                    end
                end
            end
            S_DIG: begin
                if (eng_stat.done) begin
                    n_exp   = eng_res;
                    n_state = S_IDLE;
                end
            end
            S_BASE: begin
                if (eng_stat.done) begin
                    n_x = eng_res;
                    priority if (r_e == '0) begin
                        n_state = S_OUT;
                    end else if (r_e[0]) begin
                        eng_start = 1'b1;
                        eng_a     = r_res;
                        eng_b     = OperW'(eng_res) << (OperW - MB);
                        n_state   = S_MUL;
                    end else begin
                        eng_start = 1'b1;
                        eng_a     = eng_res;
                        eng_b     = OperW'(eng_res) << (OperW - MB);
                        n_state   = S_SQR;
                    end
                end
            end
            S_MUL: begin
                if (eng_stat.done) begin
                    n_res = eng_res;
                    // no squaring once the last exponent bit is used
                    if (e_half == '0) begin
                        n_state = S_OUT;
                    end else begin
                        eng_start = 1'b1;
                        eng_a     = r_x;
                        eng_b     = OperW'(r_x) << (OperW - MB);
                        n_state   = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (eng_stat.done) begin
                    n_x = eng_res;
                    n_e = e_half;
                    priority if (e_half == '0) begin
                        n_state = S_OUT;
                    end else if (e_half[0]) begin
                        eng_start = 1'b1;
                        eng_a     = r_res;
                        eng_b     = OperW'(eng_res) << (OperW - MB);
                        n_state   = S_MUL;
                    end else begin
                        eng_start = 1'b1;
                        eng_a     = eng_res;
                        eng_b     = OperW'(eng_res) << (OperW - MB);
                        n_state   = S_SQR;
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, modulus and exponent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= MB'(MOD_RESET);
            r_exp   <= '0;
        end else begin
            r_state <= n_state;
            r_exp   <= n_exp;
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata[MB-1:0];
            end
        end
    end

    // working values
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_x   <= n_x;
        r_e   <= n_e;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_cipher <= r_res;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_cipher_value = CIPHER_W'(r_cipher);

endmodule

`default_nettype wire

@@ design/mexp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mexp_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_cfg_we,
    input wire [mexp_pkg::CIPHER_W-1:0]   i_cfg_wdata,
    input wire                            i_in_valid,
    input wire                            o_in_ready,
    input wire                            i_action,
    input wire [mexp_pkg::DIGIT_W-1:0]    i_exponent_digit,
    input wire [mexp_pkg::BYTE_W-1:0]     i_message_byte,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input wire [mexp_pkg::CIPHER_W-1:0]   o_cipher_value
);
    import mexp_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cipher_value))
        else $error("result beat dropped or changed while stalled");

    // a message byte makes the block busy, so the input is not ready right after it
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_BYTE) |=> !o_in_ready)
        else $error("input taken again right after a message byte");

    // an exponent digit never creates a result beat
    a_digit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_DIGIT) && !o_out_valid
        |=> !o_out_valid)
        else $error("result beat from an exponent digit");

    // out of reset the block is idle and empty
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_ready && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind modexp_byte_encryptor mexp_checker u_mexp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_we         (i_cfg_we),
    .i_cfg_wdata      (i_cfg_wdata),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_action         (i_action),
    .i_exponent_digit (i_exponent_digit),
    .i_message_byte   (i_message_byte),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_cipher_value   (o_cipher_value)
);

`default_nettype wire

@@ tb/modexp_byte_encryptor_tb.sv @@
`timescale 1ns / 1ps

module modexp_byte_encryptor_tb;

    import mexp_pkg::*;

    localparam int     RAND_ITEMS = 120;
    localparam int     DIR_ROWS   = 23;
    localparam int     SETTLE_CYC = 100;    // covers one digit fold
    localparam int     HOLD_CYC   = 4000;
    localparam longint TIMEOUT_NS = 64'd100_000_000;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    // one directed row: a modulus write or an input beat
    typedef struct packed {
        t_row_kind           kind;
        logic                action;
        logic [DIGIT_W-1:0]  digit;
        logic [BYTE_W-1:0]   msg;
        logic [CIPHER_W-1:0] value;    // modulus for a write, typed cipher for a beat
        logic                typed;
    } t_dir_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CIPHER_W-1:0] i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_action;
    logic [DIGIT_W-1:0]  i_exponent_digit;
    logic [BYTE_W-1:0]   i_message_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CIPHER_W-1:0] o_cipher_value;

    // predictor state and pending ciphers
    logic [CIPHER_W-1:0] pred_modulus;
    logic [CIPHER_W-1:0] pred_exponent;
    logic [CIPHER_W-1:0] cipher_q[$];
    logic [CIPHER_W-1:0] want_cipher;
    int                  err_cnt;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  hold_req;

    modexp_byte_encryptor i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_exponent_digit (i_exponent_digit),
        .i_message_byte   (i_message_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cipher_value   (o_cipher_value)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // (a * b) mod m by shift and add, m at least 1
    function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [63:0] acc;
        a   = a % m;
        b   = b % m;
        acc = 64'd0;
        for (int k = CIPHER_W - 1; k >= 0; k--) begin
            acc = acc + acc;
            if (acc >= m) acc = acc - m;
            if (b[k]) begin
                acc = acc + a;
                if (acc >= m) acc = acc - m;
            end
        end
        return acc;
    endfunction

    // right-to-left square and multiply
    function automatic logic [63:0] mod_pow(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] m);
        logic [63:0] res;
        logic [63:0] sq;
        res = 64'd1 % m;
        sq  = base % m;
        while (e != 64'd0) begin
            if (e[0]) res = mod_mul(res, sq, m);
            e  = e >> 1;
            sq = mod_mul(sq, sq, m);
        end
        return res;
    endfunction

    function automatic logic [CIPHER_W-1:0] predict_cipher(input logic [BYTE_W-1:0] msg);
        logic [63:0] p;
        if (pred_modulus < CIPHER_W'(2)) return '0;
        p = mod_pow(64'(msg), {1'b0, pred_exponent}, {1'b0, pred_modulus});
        return p[CIPHER_W-1:0];
    endfunction

    // fold one digit into the running exponent, modulo n - 1
    task automatic fold_digit(input logic [DIGIT_W-1:0] dig);
        logic [63:0] m;
        logic [63:0] e;
        if (pred_modulus < CIPHER_W'(2)) begin
            pred_exponent = '0;
        end else begin
            m = {1'b0, pred_modulus} - 64'd1;
            e = mod_mul({1'b0, pred_exponent}, 64'(DIGIT_BASE), m) + (64'(dig) % m);
            if (e >= m) e = e - m;
            pred_exponent = e[CIPHER_W-1:0];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [CIPHER_W-1:0] got,
                                   input logic [CIPHER_W-1:0] want);
        err_cnt++;
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    // offer one beat, with random gaps, and advance the predictor on acceptance
    task automatic send_item(input logic act, input logic [DIGIT_W-1:0] dig,
                             input logic [BYTE_W-1:0] msg, input bit typed,
                             input logic [CIPHER_W-1:0] typed_val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_exponent_digit <= dig;
        i_message_byte   <= msg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (act == ACT_DIGIT) fold_digit(dig);
        else if (typed) cipher_q.push_back(typed_val);
        else cipher_q.push_back(predict_cipher(msg));
    endtask

    // stop offering and wait until the block has gone quiet
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [CIPHER_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_modulus = value;    // all 63 bits kept at the default width
    endtask

    // directed table: typed ciphers only where they are plain
    function automatic t_dir_row dir_row(input int idx);
        case (idx)
            // zero exponent after reset
            0:  return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h00, 63'd1, 1'b1};
            1:  return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'hff, 63'd1, 1'b1};
            // modulus two keeps the exponent at zero
            2:  return '{ROW_ITEM, ACT_DIGIT, 4'd9,  8'h00, 63'd0, 1'b0};
            3:  return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h80, 63'd1, 1'b1};
            // modulus below two
            4:  return '{ROW_CFG,  ACT_DIGIT, 4'd0,  8'h00, 63'd0, 1'b0};
            5:  return '{ROW_ITEM, ACT_DIGIT, 4'd15, 8'h00, 63'd0, 1'b0};
            6:  return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h7f, 63'd0, 1'b1};
            7:  return '{ROW_CFG,  ACT_DIGIT, 4'd0,  8'h00, 63'd1, 1'b0};
            8:  return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'hff, 63'd0, 1'b1};
            // largest modulus, digits above nine folded as they are
            9:  return '{ROW_CFG,  ACT_DIGIT, 4'd0,  8'h00, {CIPHER_W{1'b1}}, 1'b0};
            10: return '{ROW_ITEM, ACT_DIGIT, 4'd9,  8'h00, 63'd0, 1'b0};
            11: return '{ROW_ITEM, ACT_DIGIT, 4'd15, 8'h00, 63'd0, 1'b0};
            12: return '{ROW_ITEM, ACT_DIGIT, 4'd0,  8'h00, 63'd0, 1'b0};
            13: return '{ROW_ITEM, ACT_DIGIT, 4'd8,  8'h00, 63'd0, 1'b0};
            14: return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'hff, 63'd0, 1'b0};
            15: return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h00, 63'd0, 1'b1};
            16: return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h01, 63'd1, 1'b1};
            // new modulus, stored exponent used as it stands
            17: return '{ROW_CFG,  ACT_DIGIT, 4'd0,  8'h00, 63'd251, 1'b0};
            18: return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'h02, 63'd0, 1'b0};
            19: return '{ROW_ITEM, ACT_DIGIT, 4'd3,  8'h00, 63'd0, 1'b0};
            20: return '{ROW_ITEM, ACT_BYTE,  4'd0,  8'hc3, 63'd0, 1'b0};
            21: return '{ROW_CFG,  ACT_DIGIT, 4'd0,  8'h00, 63'd3, 1'b0};
            default: return '{ROW_ITEM, ACT_BYTE, 4'd0, 8'h02, 63'd0, 1'b0};
        endcase
    endfunction

    // compare each accepted result beat with the oldest pending cipher
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("cipher with nothing pending", o_cipher_value, '0);
            end else begin
                want_cipher = cipher_q.pop_front();
                if (o_cipher_value !== want_cipher)
                    report_mismatch("cipher_value", o_cipher_value, want_cipher);
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("modexp_byte_encryptor_tb: errors");
        $finish;
    end

    initial begin : stimulus
        t_dir_row            row;
        logic [CIPHER_W-1:0] mod_val;
        logic [DIGIT_W-1:0]  dig;
        int                  items_sent;
        int                  pick;
        int                  n_grp;
        int                  n_dig;
        int                  n_msg;
        int                  k;
        bit                  large_mod;
        bit                  hold_seg;
        bit                  hold_used;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_in_valid       = 1'b0;
        i_action         = ACT_DIGIT;
        i_exponent_digit = '0;
        i_message_byte   = '0;
        pred_modulus     = CIPHER_W'(MOD_RESET);
        pred_exponent    = '0;
        err_cnt          = 0;
        send_idle_pct    = 10;
        recv_idle_pct    = 76;
        hold_req         = 1'b0;
        hold_used        = 1'b0;
        items_sent       = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_row(r);
            if (row.kind == ROW_CFG) write_modulus(row.value);
            else send_item(row.action, row.digit, row.msg, row.typed, row.value);
        end

        // random part: per modulus, runs of digits followed by message bytes
        while (items_sent < RAND_ITEMS) begin
            if (items_sent < 40) begin
                send_idle_pct = 10;
                recv_idle_pct = 76;
            end else if (items_sent < 80) begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            hold_seg  = (items_sent >= 80) && !hold_used;
            pick      = hold_seg ? 5 : $urandom_range(0, 19);
            large_mod = (pick == 1) || (pick == 2);
            if (pick == 0) begin
                mod_val = CIPHER_W'($urandom_range(0, 1));
            end else if (large_mod) begin
                mod_val = CIPHER_W'({$urandom, $urandom});
                mod_val[CIPHER_W-1] = 1'b1;
            end else begin
                k       = $urandom_range(2, hold_seg ? 8 : 12);
                mod_val = CIPHER_W'($urandom_range(2, (1 << k) - 1));
            end
            write_modulus(mod_val);

            // long stall on the result side while beats keep coming
            if (hold_seg) begin
                hold_req  = 1'b1;
                hold_used = 1'b1;
            end

            n_grp = large_mod ? 2 : $urandom_range(3, 5);
            for (int g = 0; g < n_grp; g++) begin
                n_dig = large_mod ? $urandom_range(16, 19) : $urandom_range(0, 3);
                n_msg = large_mod ? 1 : $urandom_range(1, 3);
                for (int d = 0; d < n_dig; d++) begin
                    // now and then a digit above nine
                    if ($urandom_range(0, 7) == 0) dig = DIGIT_W'($urandom_range(10, 15));
                    else dig = DIGIT_W'($urandom_range(0, 9));
                    send_item(ACT_DIGIT, dig, '0, 1'b0, '0);
                end
                for (int b = 0; b < n_msg; b++)
                    send_item(ACT_BYTE, DIGIT_W'($urandom_range(0, 15)),
                              BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                items_sent += n_dig + n_msg;
            end
        end

        settle();
        if (err_cnt == 0)
            $display("modexp_byte_encryptor_tb: clean");
        else
            $display("modexp_byte_encryptor_tb: errors");
        $finish;
    end

endmodule
